// ===== rtl/core/u8k_pkg.sv =====
// u8k_pkg: word types, decoder state and the cyrillic letter table for the
// utf-8 to koi8-r transcoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package u8k_pkg;

	localparam logic [7:0] LEAD_D0   = 8'hD0;
	localparam logic [7:0] LEAD_D1   = 8'hD1;
	localparam logic [7:0] KOI_YO_UC = 8'hB3;
	localparam logic [7:0] KOI_YO_LC = 8'hA3;
	localparam logic [5:0] LOW_YO_UC = 6'h01;
	localparam logic [5:0] LOW_YO_LC = 6'h11;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_D0   = 2'd1,
		KIND_D1   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_of_text;
	} in_word_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       text_end;
	} out_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] skip;
	} dec_state_t;

	// koi8-r codes for u+0410 .. u+044f
	function automatic logic [7:0] cyr_koi8(input logic [5:0] idx);
		logic [7:0] code;
		case (idx)
			6'd0:  code = 8'hE1; 6'd1:  code = 8'hE2; 6'd2:  code = 8'hF7; 6'd3:  code = 8'hE7;
			6'd4:  code = 8'hE4; 6'd5:  code = 8'hE5; 6'd6:  code = 8'hF6; 6'd7:  code = 8'hFA;
			6'd8:  code = 8'hE9; 6'd9:  code = 8'hEA; 6'd10: code = 8'hEB; 6'd11: code = 8'hEC;
			6'd12: code = 8'hED; 6'd13: code = 8'hEE; 6'd14: code = 8'hEF; 6'd15: code = 8'hF0;
			6'd16: code = 8'hF2; 6'd17: code = 8'hF3; 6'd18: code = 8'hF4; 6'd19: code = 8'hF5;
			6'd20: code = 8'hE6; 6'd21: code = 8'hE8; 6'd22: code = 8'hE3; 6'd23: code = 8'hFE;
			6'd24: code = 8'hFB; 6'd25: code = 8'hFD; 6'd26: code = 8'hFF; 6'd27: code = 8'hF9;
			6'd28: code = 8'hF8; 6'd29: code = 8'hFC; 6'd30: code = 8'hE0; 6'd31: code = 8'hF1;
			6'd32: code = 8'hC1; 6'd33: code = 8'hC2; 6'd34: code = 8'hD7; 6'd35: code = 8'hC7;
			6'd36: code = 8'hC4; 6'd37: code = 8'hC5; 6'd38: code = 8'hD6; 6'd39: code = 8'hDA;
			6'd40: code = 8'hC9; 6'd41: code = 8'hCA; 6'd42: code = 8'hCB; 6'd43: code = 8'hCC;
			6'd44: code = 8'hCD; 6'd45: code = 8'hCE; 6'd46: code = 8'hCF; 6'd47: code = 8'hD0;
			6'd48: code = 8'hD2; 6'd49: code = 8'hD3; 6'd50: code = 8'hD4; 6'd51: code = 8'hD5;
			6'd52: code = 8'hC6; 6'd53: code = 8'hC8; 6'd54: code = 8'hC3; 6'd55: code = 8'hDE;
			6'd56: code = 8'hDB; 6'd57: code = 8'hDD; 6'd58: code = 8'hDF; 6'd59: code = 8'hD9;
			6'd60: code = 8'hD8; 6'd61: code = 8'hDC; 6'd62: code = 8'hC0; 6'd63: code = 8'hD1;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/u8k_decode.sv =====
// u8k_decode: one-byte decode step, combinational
// depends on u8k_pkg for word types, state type and the letter table
`timescale 1ns / 1ps
`default_nettype none
module u8k_decode (
	input  var u8k_pkg::dec_state_t state,
	input  var u8k_pkg::in_word_t   word,
	output u8k_pkg::dec_state_t     state_nxt,
	output u8k_pkg::out_word_t      result
);

	logic [7:0] b;
	logic [5:0] low;
	logic       valid;
	logic [7:0] ch;
	u8k_pkg::dec_state_t nxt;

	assign b   = word.in_byte;
	assign low = b[5:0];

	always_comb begin
		valid = 1'b0;
		ch    = 8'h00;
		nxt   = state;
		case (state.kind)
			u8k_pkg::KIND_D0: begin
				// code point 0x0400 | low
				if (low == u8k_pkg::LOW_YO_UC) begin
					valid = 1'b1;
					ch    = u8k_pkg::KOI_YO_UC;
				end else if (low[5:4] != 2'b00) begin
					valid = 1'b1;
					ch    = u8k_pkg::cyr_koi8(low - 6'h10);
				end
				nxt.kind = u8k_pkg::KIND_NONE;
			end
			u8k_pkg::KIND_D1: begin
				// code point 0x0440 | low
				if (low == u8k_pkg::LOW_YO_LC) begin
					valid = 1'b1;
					ch    = u8k_pkg::KOI_YO_LC;
				end else if (low[5:4] == 2'b00) begin
					valid = 1'b1;
					ch    = u8k_pkg::cyr_koi8(low + 6'h30);
				end
				nxt.kind = u8k_pkg::KIND_NONE;
			end
			default: begin
				if (state.skip != 2'd0) begin
					nxt.skip = state.skip - 2'd1;
				end else begin
					nxt.kind = u8k_pkg::KIND_NONE;
					if (b[7] == 1'b0) begin
						valid = 1'b1;
						ch    = b;
					end else if (b == u8k_pkg::LEAD_D0) begin
						nxt.kind = u8k_pkg::KIND_D0;
					end else if (b == u8k_pkg::LEAD_D1) begin
						nxt.kind = u8k_pkg::KIND_D1;
					end else if (b inside {[8'hC0:8'hDF]}) begin
						nxt.skip = 2'd1;
					end else if (b inside {[8'hE0:8'hEF]}) begin
						nxt.skip = 2'd2;
					end else if (b inside {[8'hF0:8'hF7]}) begin
						nxt.skip = 2'd3;
					end
				end
			end
		endcase
		// end of text drops whatever is pending
		if (word.last_of_text) begin
			nxt.kind = u8k_pkg::KIND_NONE;
			nxt.skip = 2'd0;
		end
	end

	assign state_nxt         = nxt;
	assign result.char_valid = valid;
	assign result.out_char   = valid ? ch : 8'h00;
	assign result.text_end   = word.last_of_text;

endmodule
`default_nettype wire

// ===== rtl/core/utf8_cyrillic_to_koi8r_core.sv =====
// utf8_cyrillic_to_koi8r_core: top level, input register, decode step, result register
// depends on u8k_pkg and u8k_decode
`timescale 1ns / 1ps
`default_nettype none
// Transcodes a stream of utf-8 bytes, one byte per src word, into koi8-r.
// Every src word yields exactly one dst word: char_valid marks a produced
// byte in out_char (zero otherwise) and text_end copies last_of_text. ascii
// passes through, 0xd0/0xd1 leads plus the next byte give cyrillic letters
// (including yo), other multi-byte sequences and stray bytes produce no
// character. A word with last_of_text drops any pending sequence. Rate: one
// word per clock sustained while dst_ready is high; a taken src word goes
// through the input register and then the result register, where dst_valid
// marks it. These two registers sit around the combinational decode step,
// whose state (pending lead, skip count) is updated as a word moves on.
// Both registers advance under dst_ready, so a stalled result still lets
// one more word be taken into an empty input stage.
module utf8_cyrillic_to_koi8r_core (
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               src_valid,
	output logic                   src_ready,
	input  var u8k_pkg::in_word_t  src_word,
	output logic                   dst_valid,
	input  var logic               dst_ready,
	output u8k_pkg::out_word_t     dst_word
);

	// input stage
	logic                valid_s1;
	u8k_pkg::in_word_t   word_s1;
	// result stage
	logic                valid_s2;
	u8k_pkg::out_word_t  word_s2;
	// decoder state, updated when a word moves from s1 to s2
	u8k_pkg::dec_state_t state_q;
	u8k_pkg::dec_state_t state_nxt;
	u8k_pkg::out_word_t  result;

	logic adv_s2;
	logic adv_s1;

	// result register can take a word when empty or being drained
	assign adv_s2    = !valid_s2 || dst_ready;
	// input register can take a word when empty or passing its word on
	assign adv_s1    = !valid_s1 || adv_s2;
	assign src_ready = adv_s1;

	u8k_decode u_decode (
		.state     (state_q),
		.word      (word_s1),
		.state_nxt (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{kind: u8k_pkg::KIND_NONE, skip: 2'd0};
		end else begin
			if (adv_s1) begin
				valid_s1 <= src_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && src_valid) begin
			word_s1 <= src_word;
		end
		if (adv_s2 && valid_s1) begin
			word_s2 <= result;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_word  = word_s2;

	// end of text leaves the decoder idle
	a_text_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && word_s1.last_of_text) |=>
		(state_q.kind == u8k_pkg::KIND_NONE && state_q.skip == 2'd0))
		else $error("decoder state not cleared after end of text");

	// a skip count and a pending lead never coexist
	a_skip_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.skip != 2'd0) |-> (state_q.kind == u8k_pkg::KIND_NONE))
		else $error("skip count with pending lead");

	// no produced byte means a zero character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && !dst_word.char_valid) |-> (dst_word.out_char == 8'h00))
		else $error("out_char nonzero without char_valid");

	// a word in s1 that cannot move stays there
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(word_s1)))
		else $error("input stage lost a word under stall");

endmodule
`default_nettype wire
